// ----- design/id3p_pkg.sv -----
package id3p_pkg;

  // walker phases
  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_FHDR = 3'd1,
    PH_ENC  = 3'd2,
    PH_TEXT = 3'd3,
    PH_SKIP = 3'd4,
    PH_PAD  = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  // result kinds as seen on the output tuser
  typedef enum logic [2:0] {
    KIND_CONTENT = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_NO_TAG  = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] frame_tag;
    logic        text_encoding;
    logic [7:0]  content;
    logic        last;
    logic [27:0] tag_length;
  } result_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [3:0] HdrLen    = 4'd10;
  localparam logic [7:0] ChT       = 8'h54;
  localparam logic [7:0] ChI       = 8'h49;
  localparam logic [7:0] ChD       = 8'h44;
  localparam logic [7:0] Ch3       = 8'h33;
  localparam logic [6:0] SyncMask  = 7'h7F;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = ChI;
      2'd1:    m = ChD;
      default: m = Ch3;
    endcase
    return m;
  endfunction

  // syncsafe size: low 7 bits of each byte, msb first
  function automatic logic [27:0] syncsafe(input logic [31:0] hb);
    return {hb[30:24] & SyncMask, hb[22:16] & SyncMask,
            hb[14:8] & SyncMask, hb[6:0] & SyncMask};
  endfunction

endpackage

// ----- design/id3p_step.sv -----
module id3p_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              stream_end_i,
  output id3p_pkg::result_t res0_o,
  output id3p_pkg::result_t res1_o,
  output logic              push0_o,
  output logic              push1_o
);

  id3p_pkg::phase_e phase_q, phase_d;
  logic [3:0]  byte_count_q, byte_count_d;
  logic [31:0] header_bytes_q, header_bytes_d;
  logic [27:0] tag_remaining_q, tag_remaining_d;
  logic [27:0] tag_total_q, tag_total_d;
  logic [31:0] current_tag_q, current_tag_d;
  logic [31:0] frame_remaining_q, frame_remaining_d;
  logic        current_encoding_q, current_encoding_d;

  logic [27:0] tr_dec;
  logic [31:0] fr_dec;
  logic [31:0] fr_clip;
  logic        adv;
  logic        emit_item, emit_done, emit_end;
  id3p_pkg::kind_e item_kind, end_kind;
  logic        item_enc, item_last;
  logic [7:0]  item_byte;
  logic [31:0] hb_shift;

  assign tr_dec   = (phase_q != id3p_pkg::PH_HDR && tag_remaining_q != '0) ?
                    tag_remaining_q - 28'd1 : tag_remaining_q;
  assign fr_dec   = (frame_remaining_q != '0) ? frame_remaining_q - 32'd1
                                              : frame_remaining_q;
  assign fr_clip  = (frame_remaining_q > {4'd0, tr_dec}) ? {4'd0, tr_dec}
                                                         : frame_remaining_q;
  assign hb_shift = {header_bytes_q[23:0], data_byte_i};

  always_comb begin : next_state
    phase_d            = phase_q;
    byte_count_d       = byte_count_q;
    header_bytes_d     = header_bytes_q;
    tag_remaining_d    = tag_remaining_q;
    tag_total_d        = tag_total_q;
    current_tag_d      = current_tag_q;
    frame_remaining_d  = frame_remaining_q;
    current_encoding_d = current_encoding_q;
    adv       = 1'b0;
    emit_item = 1'b0;
    emit_done = 1'b0;
    emit_end  = 1'b0;
    item_kind = id3p_pkg::KIND_CONTENT;
    item_enc  = 1'b0;
    item_byte = 8'd0;
    item_last = 1'b0;
    end_kind  = id3p_pkg::KIND_NO_TAG;
    if (accept_i && phase_q != id3p_pkg::PH_DONE) begin
      tag_remaining_d = tr_dec;
      case (phase_q)
        id3p_pkg::PH_HDR: begin
          if (byte_count_q < 4'd3 &&
              data_byte_i != id3p_pkg::magic_byte(byte_count_q[1:0])) begin
            phase_d  = id3p_pkg::PH_DONE;
            emit_end = 1'b1;
          end else begin
            header_bytes_d = hb_shift;
            byte_count_d   = byte_count_q + 4'd1;
            if (byte_count_q == id3p_pkg::HdrLen - 4'd1) begin
              tag_total_d     = id3p_pkg::syncsafe(hb_shift);
              tag_remaining_d = id3p_pkg::syncsafe(hb_shift);
              adv             = 1'b1;
            end
          end
        end
        id3p_pkg::PH_FHDR: begin
          if (byte_count_q < 4'd4) begin
            current_tag_d = {current_tag_q[23:0], data_byte_i};
          end else if (byte_count_q < 4'd8) begin
            frame_remaining_d = {frame_remaining_q[23:0], data_byte_i};
          end
          byte_count_d = byte_count_q + 4'd1;
          if (byte_count_q == id3p_pkg::HdrLen - 4'd1) begin
            byte_count_d      = 4'd0;
            frame_remaining_d = fr_clip;
            if (fr_clip == '0) begin
              adv = 1'b1;
            end else if (current_tag_q[31:24] == id3p_pkg::ChT) begin
              phase_d = id3p_pkg::PH_ENC;
            end else begin
              phase_d = id3p_pkg::PH_SKIP;
            end
          end
        end
        id3p_pkg::PH_ENC: begin
          current_encoding_d = data_byte_i[0];
          frame_remaining_d  = fr_dec;
          if (data_byte_i <= 8'd1) begin
            if (fr_dec == '0) begin
              emit_item = 1'b1;
              item_kind = id3p_pkg::KIND_EMPTY;
              item_enc  = data_byte_i[0];
              adv       = 1'b1;
            end else begin
              phase_d = id3p_pkg::PH_TEXT;
            end
          end else if (fr_dec == '0) begin
            adv = 1'b1;
          end else begin
            phase_d = id3p_pkg::PH_SKIP;
          end
        end
        id3p_pkg::PH_TEXT: begin
          frame_remaining_d = fr_dec;
          emit_item = 1'b1;
          item_kind = id3p_pkg::KIND_CONTENT;
          item_enc  = current_encoding_q;
          item_byte = data_byte_i;
          item_last = (fr_dec == '0);
          adv       = (fr_dec == '0);
        end
        id3p_pkg::PH_SKIP: begin
          frame_remaining_d = fr_dec;
          adv = (fr_dec == '0);
        end
        default: begin
          adv = (tr_dec == '0);
        end
      endcase
      if (adv) begin
        byte_count_d = 4'd0;
        if (tag_remaining_d == '0) begin
          phase_d   = id3p_pkg::PH_DONE;
          emit_done = 1'b1;
        end else if (tag_remaining_d < 28'd10) begin
          phase_d = id3p_pkg::PH_PAD;
        end else begin
          phase_d = id3p_pkg::PH_FHDR;
        end
      end
      if (stream_end_i && phase_d != id3p_pkg::PH_DONE) begin
        emit_end = 1'b1;
        end_kind = (phase_d == id3p_pkg::PH_HDR) ? id3p_pkg::KIND_NO_TAG
                                                 : id3p_pkg::KIND_TRUNC;
        phase_d  = id3p_pkg::PH_DONE;
      end
    end
  end

  // at most two results: a frame item first, then done or the end report
  always_comb begin : results
    id3p_pkg::result_t item_r, fin_r;
    item_r.kind          = item_kind;
    item_r.frame_tag     = current_tag_q;
    item_r.text_encoding = item_enc;
    item_r.content       = item_byte;
    item_r.last          = item_last;
    item_r.tag_length    = tag_total_d;
    fin_r.kind           = emit_done ? id3p_pkg::KIND_DONE : end_kind;
    fin_r.frame_tag      = '0;
    fin_r.text_encoding  = 1'b0;
    fin_r.content        = '0;
    fin_r.last           = 1'b0;
    fin_r.tag_length     = tag_total_d;
    res0_o  = emit_item ? item_r : fin_r;
    res1_o  = fin_r;
    push0_o = emit_item | emit_done | emit_end;
    push1_o = emit_item & (emit_done | emit_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q            <= id3p_pkg::PH_HDR;
      byte_count_q       <= '0;
      header_bytes_q     <= '0;
      tag_remaining_q    <= '0;
      tag_total_q        <= '0;
      current_tag_q      <= '0;
      frame_remaining_q  <= '0;
      current_encoding_q <= 1'b0;
    end else begin
      phase_q            <= phase_d;
      byte_count_q       <= byte_count_d;
      header_bytes_q     <= header_bytes_d;
      tag_remaining_q    <= tag_remaining_d;
      tag_total_q        <= tag_total_d;
      current_tag_q      <= current_tag_d;
      frame_remaining_q  <= frame_remaining_d;
      current_encoding_q <= current_encoding_d;
    end
  end

endmodule

// ----- design/id3p_out_fifo.sv -----
module id3p_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  id3p_pkg::result_t res0_i,
  input  id3p_pkg::result_t res1_i,
  input  logic              push0_i,
  input  logic              push1_i,
  output logic              room_o,
  output id3p_pkg::result_t head_o,
  output logic              valid_o,
  input  logic              pop_i
);

  id3p_pkg::result_t mem_q [id3p_pkg::FifoDepth];
  logic [id3p_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [id3p_pkg::FifoCntW-1:0] count_q, count_d;
  logic [id3p_pkg::FifoPtrW-1:0] wr_next;
  logic [id3p_pkg::FifoPtrW-1:0] ptr_gap;
  logic do_pop;

  assign wr_next = wr_ptr_q + id3p_pkg::FifoPtrW'(1);
  assign do_pop  = pop_i && count_q != '0;
  assign ptr_gap = wr_ptr_q - rd_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push1_i) begin
      wr_ptr_d = wr_ptr_q + id3p_pkg::FifoPtrW'(2);
    end else if (push0_i) begin
      wr_ptr_d = wr_next;
    end
    rd_ptr_d = do_pop ? rd_ptr_q + id3p_pkg::FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q + {{(id3p_pkg::FifoCntW-1){1'b0}}, push0_i}
                       + {{(id3p_pkg::FifoCntW-1){1'b0}}, push1_i}
                       - {{(id3p_pkg::FifoCntW-1){1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push1_i) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // space for the two results one item may raise
  assign room_o  = count_q <= id3p_pkg::FifoCntW'(id3p_pkg::FifoDepth - 2);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> room_o)
    else $error("result pushed without room");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second result without first");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= id3p_pkg::FifoCntW'(id3p_pkg::FifoDepth))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != id3p_pkg::FifoCntW'(id3p_pkg::FifoDepth) |->
      id3p_pkg::FifoCntW'(ptr_gap) == count_q)
    else $error("pointers disagree with count");

endmodule

// ----- design/id3v2_frame_parser_top.sv -----
// channel   dir  tdata                                       tuser        tlast
// s_axis    in   [7:0] data_byte                             -            stream_end
// m_axis    out  [31:0] frame_tag, [32] text_encoding,      [2:0] kind   last_of_frame
//                [40:33] content_byte, [68:41] tag_length
//
// one input item per cycle while s_axis_tready is high; each item is parsed in
// the cycle it is taken and its zero to two results land in a four-deep output queue
// first result is registered in the output queue and shows on m_axis at its head
// s_axis_tready drops when fewer than two queue slots are free
// reset: walker back to tag header, queue empty; after done, no tag or
// truncated, input items are taken and dropped until the next reset
module id3v2_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // frame_tag, text_encoding, content_byte, tag_length
  output logic [2:0]  m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // last_of_frame
);

  id3p_pkg::result_t res0, res1, head;
  logic push0, push1, room, accept;

  assign accept        = s_axis_tvalid & room;
  assign s_axis_tready = room;

  id3p_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .stream_end_i (s_axis_tlast),
    .res0_o       (res0),
    .res1_o       (res1),
    .push0_o      (push0),
    .push1_o      (push1)
  );

  id3p_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res0_i  (res0),
    .res1_i  (res1),
    .push0_i (push0),
    .push1_i (push1),
    .room_o  (room),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, head.tag_length, head.content,
                         head.text_encoding, head.frame_tag};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
